[design/agsa_pkg.sv]
package agsa_pkg;

  localparam int MAX_RANK   = 4;
  localparam int DIM_WIDTH  = 10;
  localparam int ADDR_WIDTH = 40;

  // register field widths
  localparam int RANK_W    = 3;
  localparam int AXIS_W    = 2;
  localparam int DIM_REG_W = 11;

  // derived widths
  localparam int LEN_W      = DIM_WIDTH + 1;
  localparam int ER_W       = $clog2(MAX_RANK + 1);
  localparam int DIM_IDX_W  = $clog2(MAX_RANK);
  localparam int NUM_LEVELS = MAX_RANK - 1;
  localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CFG_IDX_W  = $clog2(3 + MAX_RANK);
  localparam int CFG_DATA_W = DIM_REG_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DIM0     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LAST = CFG_IDX_W'(3 + MAX_RANK - 1);

  typedef struct packed {
    logic                                   busy;
    logic                                   restart;
    logic                                   scatter;
    logic [LEN_W-1:0]                       axis_len;
    logic [ADDR_WIDTH-1:0]                  axis_stride;
    logic [NUM_LEVELS-1:0]                  level_on;
    logic [NUM_LEVELS-1:0][LEN_W-1:0]       level_len;
    logic [NUM_LEVELS-1:0][ADDR_WIDTH-1:0]  level_stride;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] offset;
    logic [ADDR_WIDTH-1:0] linear;
    logic                  last;
  } walk_t;

  function automatic logic [ER_W-1:0] eff_rank(logic [RANK_W-1:0] r);
    if (int'(r) < 2) return ER_W'(2);
    if (int'(r) > MAX_RANK) return ER_W'(MAX_RANK);
    return ER_W'(r);
  endfunction

  function automatic logic [DIM_IDX_W-1:0] eff_axis(logic [AXIS_W-1:0] a,
                                                    logic [ER_W-1:0] er);
    if (int'(a) >= int'(er) - 1) return DIM_IDX_W'(int'(er) - 2);
    return DIM_IDX_W'(a);
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(logic [DIM_REG_W-1:0] d);
    if (d == '0) return LEN_W'(1);
    if (int'(d) > (1 << DIM_WIDTH)) return LEN_W'(1 << DIM_WIDTH);
    return LEN_W'(d);
  endfunction

endpackage

[design/agsa_if.sv]
interface agsa_req_if;
  logic                              valid;
  logic                              ready;
  logic [agsa_pkg::ADDR_WIDTH-1:0]   batch_base;

  modport source(output valid, output batch_base, input ready);
  modport sink(input valid, input batch_base, output ready);
endinterface

interface agsa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [agsa_pkg::ADDR_WIDTH-1:0]   read_address;
  logic [agsa_pkg::ADDR_WIDTH-1:0]   write_address;
  logic                              last;

  modport source(output valid, output read_address, output write_address, output last,
                 input ready);
  modport sink(input valid, input read_address, input write_address, input last,
               output ready);
endinterface

[design/agsa_cfg.sv]
module agsa_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [agsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [agsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output agsa_pkg::cfg_t                     cfg
);

  logic [agsa_pkg::RANK_W-1:0]     rank;
  logic [agsa_pkg::AXIS_W-1:0]     axis_select;
  logic                            scatter_mode;
  logic [agsa_pkg::DIM_REG_W-1:0]  dim_reg [agsa_pkg::MAX_RANK];

  logic                            busy;
  logic                            load;
  logic [agsa_pkg::DIM_IDX_W-1:0]  seq_idx;
  logic [agsa_pkg::ADDR_WIDTH-1:0] cur_stride;
  logic [agsa_pkg::ADDR_WIDTH-1:0] axis_stride;
  logic [agsa_pkg::ADDR_WIDTH-1:0] level_stride [agsa_pkg::NUM_LEVELS];

  logic [agsa_pkg::ER_W-1:0]       er;
  logic [agsa_pkg::DIM_IDX_W-1:0]  ax;
  logic                            restart;
  logic                            at_top;
  logic [agsa_pkg::DIM_IDX_W-1:0]  next_idx;
  logic [agsa_pkg::LEN_W-1:0]      next_len;
  logic [agsa_pkg::ADDR_WIDTH+agsa_pkg::LEN_W-1:0] prod;
  logic [agsa_pkg::ADDR_WIDTH-1:0] stride_new;
  logic [agsa_pkg::LVL_W-1:0]      store_lvl;

  assign er      = agsa_pkg::eff_rank(rank);
  assign ax      = agsa_pkg::eff_axis(axis_select, er);
  assign restart = cfg_wr_en && (cfg_index <= agsa_pkg::REG_DIM_LAST);

  // stride chain, innermost dimension first, one multiply per cycle
  assign at_top     = (agsa_pkg::ER_W'(seq_idx) == er - agsa_pkg::ER_W'(1));
  assign next_idx   = seq_idx + agsa_pkg::DIM_IDX_W'(1);
  assign next_len   = agsa_pkg::eff_len(dim_reg[next_idx]);
  assign prod       = cur_stride * next_len;
  assign stride_new = at_top ? agsa_pkg::ADDR_WIDTH'(1) : prod[agsa_pkg::ADDR_WIDTH-1:0];
  assign store_lvl  = (seq_idx < ax) ? agsa_pkg::LVL_W'(seq_idx)
                                     : agsa_pkg::LVL_W'(seq_idx - agsa_pkg::DIM_IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rank         <= agsa_pkg::RANK_W'(2);
      axis_select  <= '0;
      scatter_mode <= 1'b0;
      for (int k = 0; k < agsa_pkg::MAX_RANK; k++) begin
        dim_reg[k] <= agsa_pkg::DIM_REG_W'(1);
      end
      busy    <= 1'b1;
      load    <= 1'b1;
      seq_idx <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          agsa_pkg::REG_RANK: rank         <= cfg_data[agsa_pkg::RANK_W-1:0];
          agsa_pkg::REG_AXIS: axis_select  <= cfg_data[agsa_pkg::AXIS_W-1:0];
          agsa_pkg::REG_MODE: scatter_mode <= cfg_data[0];
          default: begin
            if (restart) begin
              dim_reg[agsa_pkg::DIM_IDX_W'(cfg_index - agsa_pkg::REG_DIM0)] <= cfg_data;
            end
          end
        endcase
      end
      if (restart) begin
        busy <= 1'b1;
        load <= 1'b1;
      end else if (busy) begin
        if (load) begin
          load    <= 1'b0;
          seq_idx <= agsa_pkg::DIM_IDX_W'(er - agsa_pkg::ER_W'(1));
        end else if (seq_idx == '0) begin
          busy <= 1'b0;
        end else begin
          seq_idx <= seq_idx - agsa_pkg::DIM_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !load && !restart) begin
      cur_stride <= stride_new;
      if (seq_idx == ax) begin
        axis_stride <= stride_new;
      end else begin
        level_stride[store_lvl] <= stride_new;
      end
    end
  end

  always_comb begin
    cfg.busy        = busy;
    cfg.restart     = restart;
    cfg.scatter     = scatter_mode;
    cfg.axis_len    = agsa_pkg::eff_len(dim_reg[ax]);
    cfg.axis_stride = axis_stride;
    for (int j = 0; j < agsa_pkg::NUM_LEVELS; j++) begin
      cfg.level_on[j]     = (j + 1 < int'(er));
      cfg.level_len[j]    = (j < int'(ax)) ? agsa_pkg::eff_len(dim_reg[j])
                                           : agsa_pkg::eff_len(dim_reg[j+1]);
      cfg.level_stride[j] = level_stride[j];
    end
  end

endmodule

[design/agsa_walk.sv]
module agsa_walk (
  input  logic            clk,
  input  logic            rst,
  input  agsa_pkg::cfg_t  cfg,
  input  logic            step,
  output agsa_pkg::walk_t walk
);

  logic [agsa_pkg::DIM_WIDTH-1:0]  pos  [agsa_pkg::NUM_LEVELS];
  logic [agsa_pkg::ADDR_WIDTH-1:0] base [agsa_pkg::NUM_LEVELS];
  logic [agsa_pkg::DIM_WIDTH-1:0]  inner;
  logic [agsa_pkg::ADDR_WIDTH-1:0] linear;
  logic [agsa_pkg::ADDR_WIDTH-1:0] offset;

  logic                            inner_end;
  logic [agsa_pkg::NUM_LEVELS-1:0] level_end;
  logic                            last;
  logic [agsa_pkg::LVL_W-1:0]      k;
  logic [agsa_pkg::ADDR_WIDTH-1:0] kbase;
  logic [agsa_pkg::ADDR_WIDTH-1:0] kstride;
  logic [agsa_pkg::ADDR_WIDTH-1:0] sum;

  assign inner_end = (agsa_pkg::LEN_W'(inner) + agsa_pkg::LEN_W'(1)) >= cfg.axis_len;

  // deepest odometer level that can still advance, and its running base
  always_comb begin
    k       = '0;
    kbase   = '0;
    kstride = '0;
    for (int j = 0; j < agsa_pkg::NUM_LEVELS; j++) begin
      level_end[j] = !cfg.level_on[j] ||
                     ((agsa_pkg::LEN_W'(pos[j]) + agsa_pkg::LEN_W'(1)) >= cfg.level_len[j]);
      if (!level_end[j]) begin
        k       = agsa_pkg::LVL_W'(j);
        kbase   = base[j];
        kstride = cfg.level_stride[j];
      end
    end
  end

  assign last = inner_end && (&level_end);
  assign sum  = inner_end ? (kbase + kstride) : (offset + cfg.axis_stride);

  always_ff @(posedge clk) begin
    if (rst || cfg.restart || (step && last)) begin
      inner  <= '0;
      linear <= '0;
      offset <= '0;
      for (int j = 0; j < agsa_pkg::NUM_LEVELS; j++) begin
        pos[j]  <= '0;
        base[j] <= '0;
      end
    end else if (step) begin
      linear <= linear + agsa_pkg::ADDR_WIDTH'(1);
      offset <= sum;
      if (!inner_end) begin
        inner <= inner + agsa_pkg::DIM_WIDTH'(1);
      end else begin
        inner <= '0;
        for (int j = 0; j < agsa_pkg::NUM_LEVELS; j++) begin
          if (agsa_pkg::LVL_W'(j) == k) begin
            pos[j]  <= pos[j] + agsa_pkg::DIM_WIDTH'(1);
            base[j] <= sum;
          end else if (agsa_pkg::LVL_W'(j) > k) begin
            pos[j]  <= '0;
            base[j] <= sum;
          end
        end
      end
    end
  end

  assign walk.offset = offset;
  assign walk.linear = linear;
  assign walk.last   = last;

endmodule

[design/agsa_out.sv]
module agsa_out (
  input  logic                clk,
  input  logic                rst,
  input  agsa_pkg::cfg_t      cfg,
  input  agsa_pkg::walk_t     walk,
  output logic                step,
  agsa_req_if.sink            req,
  agsa_rsp_if.source          rsp
);

  logic [agsa_pkg::ADDR_WIDTH-1:0] strided;

  assign req.ready = !cfg.busy && (!rsp.valid || rsp.ready);
  assign step      = req.valid && req.ready;
  assign strided   = req.batch_base + walk.offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (step) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.read_address  <= cfg.scatter ? walk.linear : strided;
      rsp.write_address <= cfg.scatter ? strided : walk.linear;
      rsp.last          <= walk.last;
    end
  end

endmodule

[design/axis_gather_scatter_address_gen_unit.sv]
// Strided gather / scatter address generator.
// req  : one transfer per address pair wanted; carries batch_base, the element
//        offset of the current array in the batch.
// rsp  : read_address / write_address pair plus last, set on the final pair of
//        a full sweep over the array, after which the counters restart.
// cfg  : write-only port (cfg_wr_en, cfg_index, cfg_data). Index 0 rank,
//        1 axis_select, 2 scatter_mode, 3..6 dimension lengths. A write to
//        index 0..6 restarts the sweep and rebuilds the stride table.
// Output: the pair for an accepted req transfer is registered into rsp.
// Throughput: one pair per clock when rsp is ready; the odometer update is a
// single add per cycle, so a new req is taken while the previous pair is taken.
// Stride rebuild: after reset or a write, req.ready stays low while one
// multiplier walks the strides from the innermost dimension.
// Stall: if rsp is held, the pair waits in the output register and req.ready
// drops until it is taken; nothing is lost or repeated.
// Reset: rst (synchronous) restores rank 2, axis 0, gather, all lengths 1.
module axis_gather_scatter_address_gen_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [agsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [agsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  agsa_req_if.sink                           req,
  agsa_rsp_if.source                         rsp
);

  agsa_pkg::cfg_t  cfg;
  agsa_pkg::walk_t walk;
  logic            step;

  // config registers and stride table sequencer
  agsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // inner counter, odometer and running strided offset
  agsa_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .walk (walk)
  );

  // handshake, batch base add, output register
  agsa_out u_out (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .walk (walk),
    .step (step),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

[verif/axis_gather_scatter_address_gen_unit_tb.sv]
`timescale 1ns / 100ps

// Checks the strided gather / scatter address generator.
// A short table of requests and register writes runs first. The rows right
// after reset carry a hand-written pair. Every other row, and the random
// phases that follow, are checked against a predictor of the odometer walk.
// Each random phase rewrites some registers while the block is idle, then
// sends whole sweeps, plus up to two more requests, where the sweep is short.
module axis_gather_scatter_address_gen_unit_tb;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 2;
  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_ITEMS  = 80;     // tail of the run with no idling
  localparam int HOLD_CYCLES  = 60;     // long receiver hold-off, done once
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 100;    // keeps the log short on a bad build
  localparam int N_DIRECTED   = 26;

  typedef logic [agsa_pkg::ADDR_WIDTH-1:0] addr_t;
  typedef logic [agsa_pkg::CFG_IDX_W-1:0]  reg_idx_t;
  typedef logic [agsa_pkg::CFG_DATA_W-1:0] reg_data_t;

  // first index past the dimension registers: written, but has no effect
  localparam reg_idx_t REG_UNUSED = reg_idx_t'(agsa_pkg::REG_DIM_LAST + 1);
  localparam reg_idx_t REG_DIM1   = reg_idx_t'(agsa_pkg::REG_DIM0 + 1);
  localparam reg_idx_t REG_DIM2   = reg_idx_t'(agsa_pkg::REG_DIM_LAST - 1);
  localparam addr_t    ADDR_MAX   = '1;

  typedef struct packed {
    addr_t rd_addr;
    addr_t wr_addr;
    logic  last;
  } pair_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e kind;
    reg_idx_t  idx;
    reg_data_t data;
    addr_t     base;
    bit        has_want;   // pair typed in by hand rather than predicted
    pair_t     want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_wr_en;
  reg_idx_t  cfg_index;
  reg_data_t cfg_data;

  agsa_req_if req_ch();
  agsa_rsp_if rsp_ch();

  axis_gather_scatter_address_gen_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: register copy, odometer state and stride table
  // ---------------------------------------------------------------------
  logic [agsa_pkg::RANK_W-1:0]    cfg_rank;
  logic [agsa_pkg::AXIS_W-1:0]    cfg_axis;
  logic                           cfg_scatter;
  logic [agsa_pkg::DIM_REG_W-1:0] cfg_dim_len [agsa_pkg::MAX_RANK];

  int unsigned odo_pos [agsa_pkg::MAX_RANK-1];   // other axes, last one fastest
  int unsigned run_pos;                          // position along the contiguous axis
  addr_t       linear_pos;
  addr_t       stride_tab [agsa_pkg::MAX_RANK];

  pair_t pending_pairs [$];

  int  n_sent, n_checked, n_errors, n_sweeps, n_writes, n_random, n_directed_items;
  int  longest_hold;
  int  cycle_count;
  bit  quiet, hold_pending, hold_active;

  row_t directed_rows [N_DIRECTED];

  // rank below 2 acts as 2, above MAX_RANK as MAX_RANK
  function automatic int ranks_in_use();
    if (cfg_rank < 2) return 2;
    if (cfg_rank > agsa_pkg::MAX_RANK) return agsa_pkg::MAX_RANK;
    return int'(cfg_rank);
  endfunction

  // an axis at or past the last one folds back to rank - 2
  function automatic int contiguous_axis();
    int r;
    r = ranks_in_use();
    return (int'(cfg_axis) >= r - 1) ? r - 2 : int'(cfg_axis);
  endfunction

  // zero reads as one, anything past 2^DIM_WIDTH saturates
  function automatic int dim_length(int k);
    if (cfg_dim_len[k] == '0) return 1;
    if (int'(cfg_dim_len[k]) > (1 << agsa_pkg::DIM_WIDTH)) return 1 << agsa_pkg::DIM_WIDTH;
    return int'(cfg_dim_len[k]);
  endfunction

  function automatic longint sweep_length();
    longint n;
    n = 1;
    for (int k = 0; k < ranks_in_use(); k++) n *= dim_length(k);
    return n;
  endfunction

  // clears the walk and rebuilds row-major strides, innermost first
  function automatic void restart_sweep();
    int r;
    r = ranks_in_use();
    foreach (odo_pos[j]) odo_pos[j] = 0;
    run_pos    = 0;
    linear_pos = '0;
    foreach (stride_tab[k]) stride_tab[k] = '0;
    stride_tab[r-1] = addr_t'(1);
    for (int k = r - 1; k > 0; k--)
      stride_tab[k-1] = stride_tab[k] * addr_t'(dim_length(k));
  endfunction

  function automatic void reset_predictor();
    cfg_rank    = agsa_pkg::RANK_W'(2);
    cfg_axis    = '0;
    cfg_scatter = 1'b0;
    foreach (cfg_dim_len[k]) cfg_dim_len[k] = agsa_pkg::DIM_REG_W'(1);
    restart_sweep();
  endfunction

  // any write to a real register restarts the sweep; the spare index does not
  function automatic void apply_reg(reg_idx_t idx, reg_data_t data);
    case (idx)
      agsa_pkg::REG_RANK: cfg_rank    = data[agsa_pkg::RANK_W-1:0];
      agsa_pkg::REG_AXIS: cfg_axis    = data[agsa_pkg::AXIS_W-1:0];
      agsa_pkg::REG_MODE: cfg_scatter = data[0];
      default: begin
        if (idx >= agsa_pkg::REG_DIM0 && idx <= agsa_pkg::REG_DIM_LAST)
          cfg_dim_len[idx - agsa_pkg::REG_DIM0] = data[agsa_pkg::DIM_REG_W-1:0];
        else
          return;
      end
    endcase
    restart_sweep();
  endfunction

  // works out the pair for one request and steps the odometer
  function automatic pair_t next_pair(addr_t base);
    int    r, ax, n_other;
    int    other_dim [agsa_pkg::MAX_RANK];
    addr_t strided;
    pair_t p;
    bit    run_end, odo_end;
    r       = ranks_in_use();
    ax      = contiguous_axis();
    n_other = 0;
    for (int k = 0; k < r; k++)
      if (k != ax) other_dim[n_other++] = k;

    strided = base;
    for (int j = 0; j < n_other; j++)
      strided += addr_t'(odo_pos[j]) * stride_tab[other_dim[j]];
    strided += addr_t'(run_pos) * stride_tab[ax];

    p.rd_addr = cfg_scatter ? linear_pos : strided;
    p.wr_addr = cfg_scatter ? strided : linear_pos;

    run_end = (run_pos + 1 >= dim_length(ax));
    odo_end = 1'b1;
    for (int j = 0; j < n_other; j++)
      if (odo_pos[j] + 1 < dim_length(other_dim[j])) odo_end = 1'b0;
    p.last = run_end && odo_end;

    if (p.last) begin
      foreach (odo_pos[j]) odo_pos[j] = 0;
      run_pos    = 0;
      linear_pos = '0;
      return p;
    end
    linear_pos += 1;
    if (!run_end) begin
      run_pos++;
      return p;
    end
    run_pos = 0;
    for (int j = n_other; j > 0; j--) begin
      if (odo_pos[j-1] + 1 < dim_length(other_dim[j-1])) begin
        odo_pos[j-1]++;
        break;
      end
      odo_pos[j-1] = 0;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic row_t item_row(addr_t base);
    return '{ROW_ITEM, agsa_pkg::REG_RANK, '0, base, 1'b0, '0};
  endfunction

  // only used where the walk has a single element, so read = base, write = 0
  function automatic row_t checked_row(addr_t base);
    return '{ROW_ITEM, agsa_pkg::REG_RANK, '0, base, 1'b1, '{base, '0, 1'b1}};
  endfunction

  function automatic row_t write_row(reg_idx_t idx, reg_data_t data);
    return '{ROW_WRITE, idx, data, '0, 1'b0, '0};
  endfunction

  function automatic addr_t random_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ADDR_MAX;
      2:       return ADDR_MAX - addr_t'($urandom_range(0, 4096));   // wraps soon
      default: return addr_t'({$urandom, $urandom});
    endcase
  endfunction

  // mostly sensible settings, now and then out of range or with junk upper bits
  function automatic reg_data_t random_reg_value(reg_idx_t idx);
    reg_data_t v;
    case (idx)
      agsa_pkg::REG_RANK: v = ($urandom_range(0, 5) == 0) ? reg_data_t'($urandom_range(0, 7))
                                                           : reg_data_t'($urandom_range(2, 4));
      agsa_pkg::REG_AXIS: v = reg_data_t'($urandom_range(0, 3));
      agsa_pkg::REG_MODE: v = reg_data_t'($urandom_range(0, 1));
      default: begin
        case ($urandom_range(0, 19))
          0:       v = '0;
          1:       v = reg_data_t'(1 << agsa_pkg::DIM_WIDTH);
          2:       v = reg_data_t'($urandom_range((1 << agsa_pkg::DIM_WIDTH) + 1,
                                                  (1 << agsa_pkg::DIM_REG_W) - 1));
          3:       v = reg_data_t'($urandom_range(5, (1 << agsa_pkg::DIM_WIDTH) - 1));
          default: v = reg_data_t'($urandom_range(1, 4));
        endcase
      end
    endcase
    if (idx < agsa_pkg::REG_DIM0 && $urandom_range(0, 7) == 0)
      v |= reg_data_t'($urandom) & ~reg_data_t'(7);
    return v;
  endfunction

  // offer one base, record the pair at the accepting edge, maybe idle after
  task automatic send_base(addr_t base, bit has_want, pair_t want, output pair_t got);
    req_ch.valid      <= 1'b1;
    req_ch.batch_base <= base;
    do @(posedge clk); while (!req_ch.ready);
    got = next_pair(base);
    pending_pairs.push_back(has_want ? want : got);
    n_sent++;
    if (!quiet && !hold_pending && !hold_active && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // one result per request, so idle once every sent request has been answered
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (n_checked < n_sent);
  endtask

  // leading edge keeps the enable from dropping and rising in one step
  task automatic write_reg(reg_idx_t idx, reg_data_t data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_wr_en <= 1'b0;
    n_writes++;
  endtask

  task automatic flag_mismatch(string field, addr_t want, addr_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------
  // Response side: pacing and checking
  // ---------------------------------------------------------------------
  initial begin : rsp_pacing
    int held;
    forever begin
      if (hold_pending) begin
        // long hold-off: output register fills and req.ready must drop
        hold_active  = 1'b1;
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        if (held > longest_hold) longest_hold = held;
        hold_active = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_checked++;
      if (rsp_ch.last) n_sweeps++;
      if (pending_pairs.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: unexpected transfer: expected none, got rd %h wr %h last %b",
                   $time, rsp_ch.read_address, rsp_ch.write_address, rsp_ch.last);
      end else begin
        want = pending_pairs.pop_front();
        if (rsp_ch.read_address !== want.rd_addr)
          flag_mismatch("read_address", want.rd_addr, rsp_ch.read_address);
        if (rsp_ch.write_address !== want.wr_addr)
          flag_mismatch("write_address", want.wr_addr, rsp_ch.write_address);
        if (rsp_ch.last !== want.last)
          flag_mismatch("last", addr_t'(want.last), addr_t'(rsp_ch.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timed out after %0d cycles, %0d of %0d requests answered",
               $time, cycle_count, n_checked, n_sent);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    pair_t  got;
    addr_t  base, sweep_base;
    longint sweep;
    int     n_items, phase;

    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= agsa_pkg::REG_RANK;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.batch_base <= '0;

    directed_rows = '{
      // reset state: rank 2, all lengths 1, so every transfer ends a sweep
      checked_row('0),
      checked_row(ADDR_MAX),
      checked_row(40'h55_5555_5555),
      checked_row(40'hAA_AAAA_AAAA),
      // 3 x 2 array, axis 0 contiguous: one full sweep of six pairs
      write_row(agsa_pkg::REG_DIM0, 11'd3),
      write_row(REG_DIM1, 11'd2),
      item_row(40'h100), item_row(40'h100), item_row(40'h100),
      item_row(40'h100), item_row(40'h100), item_row(40'h100),
      // scatter with junk upper bits; strided side wraps past the top
      write_row(agsa_pkg::REG_MODE, 11'h7FF),
      item_row(ADDR_MAX - 1),
      item_row(ADDR_MAX - 1),
      // rank below range then above range, axis folded back, zero and oversize lengths
      write_row(agsa_pkg::REG_RANK, 11'd0),
      write_row(agsa_pkg::REG_RANK, 11'd7),
      write_row(agsa_pkg::REG_AXIS, 11'd3),
      write_row(agsa_pkg::REG_DIM_LAST, 11'd0),
      write_row(REG_DIM2, 11'd2047),
      item_row('0),
      item_row(ADDR_MAX),
      // spare index: sweep must carry on where it was
      write_row(REG_UNUSED, 11'h555),
      item_row('0),
      write_row(agsa_pkg::REG_MODE, 11'd0),
      item_row(40'h12_3456_789A)
    };

    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_base(directed_rows[i].base, directed_rows[i].has_want,
                  directed_rows[i].want, got);
        n_directed_items++;
      end
    end

    // random phases: new settings while idle, then requests with a
    // fixed base per sweep and the odd stray base mixed in
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      wait_idle();
      quiet = (n_random >= RANDOM_ITEMS - QUIET_ITEMS);
      for (int k = int'(agsa_pkg::REG_RANK); k <= int'(agsa_pkg::REG_DIM_LAST); k++)
        if (phase == 0 || $urandom_range(0, 3) != 0)
          write_reg(reg_idx_t'(k), random_reg_value(reg_idx_t'(k)));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, reg_data_t'($urandom));
      if (phase == 0) hold_pending = 1'b1;

      sweep = sweep_length();
      if (sweep <= 48)
        n_items = int'(sweep) * $urandom_range(1, 3) + $urandom_range(0, 2);
      else
        n_items = $urandom_range(8, 40);
      if (phase == 0 && n_items < 48) n_items = 48;
      if (n_items > RANDOM_ITEMS - n_random) n_items = RANDOM_ITEMS - n_random;

      sweep_base = random_base();
      repeat (n_items) begin
        base = ($urandom_range(0, 9) == 0) ? random_base() : sweep_base;
        send_base(base, 1'b0, '0, got);
        if (got.last) sweep_base = random_base();
      end
      n_random += n_items;
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      n_errors++;
      $display("%0t ns: %0d expected pairs never arrived", $time, pending_pairs.size());
    end

    $display("Covered %0d requests (%0d table, %0d random in %0d phases), %0d writes",
             n_sent, n_directed_items, n_random, phase, n_writes);
    $display("Checked %0d pairs, %0d full sweeps, receiver hold-off of %0d cycles, %0d errors",
             n_checked, n_sweeps, longest_hold, n_errors);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[axis_gather_scatter_address_gen_unit.f]
design/agsa_pkg.sv
design/agsa_if.sv
design/agsa_cfg.sv
design/agsa_walk.sv
design/agsa_out.sv
design/axis_gather_scatter_address_gen_unit.sv
verif/axis_gather_scatter_address_gen_unit_tb.sv
